// File: rtl/mfca_pkg.sv
// ---------------------------------------------------------------------------
// mfca_pkg
// Shared types and constants of the media frame chunk aggregator.
// ---------------------------------------------------------------------------
package mfca_pkg;

   // field widths
   localparam int unsigned FRAME_BYTES_W = 24;
   localparam int unsigned SEC_W         = 31;
   localparam int unsigned SUB_W         = 20;
   localparam int unsigned STAMP_W       = SEC_W + SUB_W;
   localparam int unsigned NUM_W         = 32;
   localparam int unsigned FRAMES_W      = 16;
   localparam int unsigned BYTES_W       = 32;
   localparam int unsigned THR_W         = 24;
   localparam int unsigned CSR_IDX_W     = 1;
   localparam int unsigned CSR_DATA_W    = THR_W;

   // per-frame header added to the payload length
   localparam int unsigned HEADER_BYTES  = 20;

   // command codes on the request channel
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // fill strategies
   localparam logic FILL_BY_COUNT = 1'b0;
   localparam logic FILL_BY_BYTES = 1'b1;

   // decoupling queue between front and back
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_PTR_W = 1;
   localparam int unsigned Q_CNT_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILL_STRATEGY  = 1'd0,
      CSR_FILL_THRESHOLD = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_FLUSH = 2'd1,
      OP_SKIP  = 2'd2
   } op_type;

   // classified item held in the queue
   typedef struct packed {
      op_type                   op;
      logic                     sid;
      logic [FRAME_BYTES_W-1:0] bytes;
      logic [STAMP_W-1:0]       stamp;
   } entry_type;

   // queue status seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

   // result item
   typedef struct packed {
      logic                out_stream;
      logic [NUM_W-1:0]    chunk_number;
      logic [FRAMES_W-1:0] chunk_frames;
      logic [BYTES_W-1:0]  chunk_bytes;
      logic [BYTES_W-1:0]  header_offset;
      logic [SEC_W-1:0]    first_sec;
      logic [SUB_W-1:0]    first_sub;
      logic [SEC_W-1:0]    last_sec;
      logic [SUB_W-1:0]    last_sub;
      logic                chunk_done;
   } rsp_type;

endpackage

// File: rtl/mfca_if.sv
// ---------------------------------------------------------------------------
// mfca channel interfaces
// Valid/ready request and response channels of the chunk aggregator.
// ---------------------------------------------------------------------------
interface mfca_req_if import mfca_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic                     stream_id;
   logic [FRAME_BYTES_W-1:0] frame_bytes;
   logic [SEC_W-1:0]         stamp_sec;
   logic [SUB_W-1:0]         stamp_sub;

   modport source (output valid, cmd, stream_id, frame_bytes, stamp_sec, stamp_sub,
                   input ready);
   modport sink   (input valid, cmd, stream_id, frame_bytes, stamp_sec, stamp_sub,
                   output ready);
endinterface

interface mfca_rsp_if import mfca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                out_stream;
   logic [NUM_W-1:0]    chunk_number;
   logic [FRAMES_W-1:0] chunk_frames;
   logic [BYTES_W-1:0]  chunk_bytes;
   logic [BYTES_W-1:0]  header_offset;
   logic [SEC_W-1:0]    first_sec;
   logic [SUB_W-1:0]    first_sub;
   logic [SEC_W-1:0]    last_sec;
   logic [SUB_W-1:0]    last_sub;
   logic                chunk_done;

   modport source (output valid, out_stream, chunk_number, chunk_frames, chunk_bytes,
                   header_offset, first_sec, first_sub, last_sec, last_sub, chunk_done,
                   input ready);
   modport sink   (input valid, out_stream, chunk_number, chunk_frames, chunk_bytes,
                   header_offset, first_sec, first_sub, last_sec, last_sub, chunk_done,
                   output ready);
endinterface

// File: rtl/mfca_front.sv
// ---------------------------------------------------------------------------
// mfca_front
// Accepts request transfers, classifies them and holds them in a short queue.
// ---------------------------------------------------------------------------
module mfca_front import mfca_pkg::*; #(
   parameter int unsigned NUM_STREAMS = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_cmd,
   input  logic                     req_stream_id,
   input  logic [FRAME_BYTES_W-1:0] req_frame_bytes,
   input  logic [SEC_W-1:0]         req_stamp_sec,
   input  logic [SUB_W-1:0]         req_stamp_sub,
   output queue_head_type           head,
   input  logic                     pop
);

   entry_type            q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   entry_type            new_entry;
   logic                 push;

   // classify the incoming item
   always_comb begin
      new_entry.sid   = req_stream_id;
      new_entry.bytes = req_frame_bytes;
      new_entry.stamp = {req_stamp_sec, req_stamp_sub};
      if (32'(req_stream_id) >= NUM_STREAMS) begin
         new_entry.op = OP_SKIP;
      end else if (req_cmd == CMD_FLUSH) begin
         new_entry.op = OP_FLUSH;
      end else begin
         new_entry.op = OP_ADD;
      end
   end

   assign req_ready = (cnt_ff != Q_CNT_W'(Q_DEPTH));
   assign push      = req_valid && req_ready;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.entry = q_ff[rd_ptr_ff];

endmodule

// File: rtl/mfca_back.sv
// ---------------------------------------------------------------------------
// mfca_back
// Per-stream chunk state: opens, fills and closes chunks, registers results.
// ---------------------------------------------------------------------------
module mfca_back import mfca_pkg::*; #(
   parameter int unsigned NUM_STREAMS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fill_strategy,
   input  logic [THR_W-1:0] fill_threshold,
   input  queue_head_type   head,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp
);

   localparam int unsigned SidxW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   logic [NUM_W-1:0]    next_ff, next_in;
   logic                open_ff  [NUM_STREAMS];
   logic [NUM_W-1:0]    num_ff   [NUM_STREAMS];
   logic [FRAMES_W-1:0] fc_ff    [NUM_STREAMS];
   logic [BYTES_W-1:0]  bc_ff    [NUM_STREAMS];
   logic [STAMP_W-1:0]  first_ff [NUM_STREAMS];
   logic [STAMP_W-1:0]  last_ff  [NUM_STREAMS];
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SidxW-1:0]    sidx;
   logic                cur_open;
   logic [FRAMES_W-1:0] cur_fc, base_fc;
   logic [BYTES_W-1:0]  cur_bc, base_bc;
   logic [STAMP_W-1:0]  cur_first, cur_last;
   logic [NUM_W-1:0]    cur_num;
   logic [BYTES_W:0]    sum;
   logic                wr_en;
   logic                open_upd;
   logic [NUM_W-1:0]    num_upd;
   logic [FRAMES_W-1:0] fc_upd;
   logic [BYTES_W-1:0]  bc_upd;
   logic [STAMP_W-1:0]  first_upd, last_upd;
   logic                filled, flush_done;

   assign sidx = SidxW'(head.entry.sid);
   assign pop  = head.valid && (!rsp_valid_ff || rsp_ready);

   // read the addressed stream
   always_comb begin
      cur_open  = open_ff[sidx];
      cur_num   = num_ff[sidx];
      cur_fc    = fc_ff[sidx];
      cur_bc    = bc_ff[sidx];
      cur_first = first_ff[sidx];
      cur_last  = last_ff[sidx];
   end

   // frame accumulation: a closed stream starts a fresh chunk
   always_comb begin
      base_fc = cur_open ? cur_fc : '0;
      base_bc = cur_open ? cur_bc : '0;
      sum     = {1'b0, base_bc} + (BYTES_W+1)'(head.entry.bytes)
              + (BYTES_W+1)'(HEADER_BYTES);
      bc_upd  = sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
      fc_upd  = (base_fc == '1) ? base_fc : base_fc + 1'b1;
      if (base_fc == '0) begin
         first_upd = head.entry.stamp;
         last_upd  = head.entry.stamp;
      end else begin
         first_upd = (head.entry.stamp < cur_first) ? head.entry.stamp : cur_first;
         last_upd  = (head.entry.stamp > cur_last)  ? head.entry.stamp : cur_last;
      end
      num_upd = cur_open ? cur_num : next_ff;
      if (fill_strategy == FILL_BY_BYTES) begin
         filled = (bc_upd >= BYTES_W'(fill_threshold));
      end else begin
         filled = (THR_W'(fc_upd) == fill_threshold);
      end
      flush_done = cur_open && (cur_fc != '0);
   end

   // state write-back and result formation
   always_comb begin
      wr_en    = 1'b0;
      open_upd = cur_open;
      next_in  = next_ff;
      rsp_in   = '0;
      rsp_in.out_stream = head.entry.sid;
      case (head.entry.op)
         OP_ADD: begin
            wr_en    = pop;
            open_upd = !filled;
            if (pop && !cur_open) begin
               next_in = next_ff + 1'b1;
            end
            rsp_in.chunk_number  = num_upd;
            rsp_in.chunk_frames  = fc_upd;
            rsp_in.chunk_bytes   = bc_upd;
            rsp_in.header_offset = base_bc;
            rsp_in.first_sec     = first_upd[STAMP_W-1:SUB_W];
            rsp_in.first_sub     = first_upd[SUB_W-1:0];
            rsp_in.last_sec      = last_upd[STAMP_W-1:SUB_W];
            rsp_in.last_sub      = last_upd[SUB_W-1:0];
            rsp_in.chunk_done    = filled;
         end
         OP_FLUSH: begin
            open_upd = cur_open && !flush_done;
            rsp_in.chunk_number  = cur_num;
            rsp_in.chunk_frames  = cur_fc;
            rsp_in.chunk_bytes   = cur_bc;
            rsp_in.first_sec     = cur_first[STAMP_W-1:SUB_W];
            rsp_in.first_sub     = cur_first[SUB_W-1:0];
            rsp_in.last_sec      = cur_last[STAMP_W-1:SUB_W];
            rsp_in.last_sub      = cur_last[SUB_W-1:0];
            rsp_in.chunk_done    = flush_done;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   // per-stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= NUM_W'(1);
         for (int i = 0; i < NUM_STREAMS; i++) begin
            open_ff[i]  <= 1'b0;
            num_ff[i]   <= '0;
            fc_ff[i]    <= '0;
            bc_ff[i]    <= '0;
            first_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
      end else begin
         next_ff <= next_in;
         if (pop && head.entry.op == OP_FLUSH) begin
            open_ff[sidx] <= open_upd;
         end
         if (wr_en) begin
            open_ff[sidx]  <= open_upd;
            num_ff[sidx]   <= num_upd;
            fc_ff[sidx]    <= fc_upd;
            bc_ff[sidx]    <= bc_upd;
            first_ff[sidx] <= first_upd;
            last_ff[sidx]  <= last_upd;
         end
      end
   end

   // output register
   assign rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/media_frame_chunk_aggregator.sv
// ---------------------------------------------------------------------------
// media_frame_chunk_aggregator
// Groups frames of several media streams into numbered chunks.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per transfer: add a frame (size and timestamp)
//   to its stream's open chunk, or flush that stream's chunk. rsp_ch returns
//   exactly one result per item, in order, with the chunk's number, frame
//   and byte counts, header offset, timestamp span and a done flag. csr_*
//   writes fill_strategy and fill_threshold; the user must do so only while
//   the block is idle; the block itself does not enforce it.
// Throughput:
//   one item per cycle unless rsp_ch stalls, by read-modify-write of the
//   per-stream state; items pass the queue, then the output register.
// Reset:
//   synchronous; the sequence counter restarts at 1, all chunks are closed
//   and both the queue and the output register are emptied.
// Stalls:
//   while rsp_ch is stalled the result stays in the output register and up
//   to two further items wait in the queue before req_ch.ready drops.
// ---------------------------------------------------------------------------
module media_frame_chunk_aggregator import mfca_pkg::*; #(
   parameter int unsigned NUM_STREAMS = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   mfca_req_if.sink              req_ch,
   mfca_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   logic             fill_strategy_ff, fill_strategy_in;
   logic [THR_W-1:0] fill_threshold_ff, fill_threshold_in;
   queue_head_type   head;
   logic             pop;
   rsp_type          rsp;

   // configuration registers
   always_comb begin
      fill_strategy_in  = fill_strategy_ff;
      fill_threshold_in = fill_threshold_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FILL_STRATEGY:  fill_strategy_in  = csr_wr_data[0];
            CSR_FILL_THRESHOLD: fill_threshold_in = csr_wr_data[THR_W-1:0];
            default:            fill_strategy_in  = fill_strategy_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_strategy_ff  <= FILL_BY_COUNT;
         fill_threshold_ff <= '0;
      end else begin
         fill_strategy_ff  <= fill_strategy_in;
         fill_threshold_ff <= fill_threshold_in;
      end
   end

   // front end: accept and classify
   mfca_front #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_cmd         (req_ch.cmd),
      .req_stream_id   (req_ch.stream_id),
      .req_frame_bytes (req_ch.frame_bytes),
      .req_stamp_sec   (req_ch.stamp_sec),
      .req_stamp_sub   (req_ch.stamp_sub),
      .head            (head),
      .pop             (pop)
   );

   // back end: chunk state and results
   mfca_back #(
      .NUM_STREAMS (NUM_STREAMS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .fill_strategy  (fill_strategy_ff),
      .fill_threshold (fill_threshold_ff),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp            (rsp)
   );

   assign rsp_ch.out_stream    = rsp.out_stream;
   assign rsp_ch.chunk_number  = rsp.chunk_number;
   assign rsp_ch.chunk_frames  = rsp.chunk_frames;
   assign rsp_ch.chunk_bytes   = rsp.chunk_bytes;
   assign rsp_ch.header_offset = rsp.header_offset;
   assign rsp_ch.first_sec     = rsp.first_sec;
   assign rsp_ch.first_sub     = rsp.first_sub;
   assign rsp_ch.last_sec      = rsp.last_sec;
   assign rsp_ch.last_sub      = rsp.last_sub;
   assign rsp_ch.chunk_done    = rsp.chunk_done;

endmodule

// File: rtl/mfca_checker.sv
// ---------------------------------------------------------------------------
// mfca_checker
// Port-level checks on the result channel of the chunk aggregator.
// ---------------------------------------------------------------------------
module mfca_checker import mfca_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [FRAMES_W-1:0] chunk_frames,
   input logic [BYTES_W-1:0]  chunk_bytes,
   input logic [BYTES_W-1:0]  header_offset,
   input logic [SEC_W-1:0]    first_sec,
   input logic [SUB_W-1:0]    first_sub,
   input logic [SEC_W-1:0]    last_sec,
   input logic [SUB_W-1:0]    last_sub,
   input logic                chunk_done
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // a closed chunk always holds at least one frame
   a_done_frames: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && chunk_done |-> chunk_frames != '0)
      else $error("chunk closed with no frames");

   // earliest stamp never later than latest stamp
   a_stamp_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {first_sec, first_sub} <= {last_sec, last_sub})
      else $error("timestamp span inverted");

   // header offset lies within the payload
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> header_offset <= chunk_bytes)
      else $error("header offset beyond payload length");

endmodule

bind media_frame_chunk_aggregator mfca_checker u_mfca_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .chunk_frames  (rsp_ch.chunk_frames),
   .chunk_bytes   (rsp_ch.chunk_bytes),
   .header_offset (rsp_ch.header_offset),
   .first_sec     (rsp_ch.first_sec),
   .first_sub     (rsp_ch.first_sub),
   .last_sec      (rsp_ch.last_sec),
   .last_sub      (rsp_ch.last_sub),
   .chunk_done    (rsp_ch.chunk_done)
);
